// ===== hdl/bfvc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfvc_pkg
// types, constants and gain tables shared by the body-frame velocity command
// ----------------------------------------------------------------------------
package bfvc_pkg;

   localparam int ITERS = 31;
   localparam int DIV_CELLS = 3;
   localparam int DIV_CHUNK = 14;
   localparam int DIV_WIDTH = DIV_CELLS * DIV_CHUNK;

   localparam logic [2:0] MODE_ZERO_LO   = 3'd0;
   localparam logic [2:0] MODE_HOLD      = 3'd1;
   localparam logic [2:0] MODE_POSITION  = 3'd2;
   localparam logic [2:0] MODE_VELOCITY  = 3'd3;
   localparam logic [2:0] MODE_PASS      = 3'd4;
   localparam logic [2:0] MODE_MIX_UP    = 3'd5;
   localparam logic [2:0] MODE_MIX_DOWN  = 3'd6;
   localparam logic [2:0] MODE_ZERO_HI   = 3'd7;

   localparam logic signed [33:0] COS_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
   localparam logic [16:0] RECIP_FIVE = 17'd52429;

   typedef enum logic [1:0] {KFF_ZERO, KFF_PLUS, KFF_MINUS} kff_type;
   typedef enum logic [1:0] {KP_ZERO, KP_FIFTH, KP_ONE} kp_type;

   typedef struct packed {
      logic        [2:0]  mode;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic        [31:0] hdg_rate;
      logic signed [21:0] err_x;
      logic signed [21:0] err_y;
      logic signed [21:0] err_z;
      logic        [15:0] heading;
      logic               zero_quat;
      logic        [31:0] yaw_turn;
      logic        [31:0] cmd_rate;
   } payload_type;

   typedef struct packed {
      logic signed [39:0] x;
      logic signed [39:0] y;
      logic        [31:0] acc;
   } vec_state_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic        [31:0] a;
   } rot_state_type;

   typedef struct packed {
      logic [DIV_WIDTH-1:0] u;
      logic [2:0]           rem;
   } div_state_type;

   function automatic logic [31:0] atan_turn(input int step);
      logic [31:0] r;
      unique case (step)
         0:  r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
         3:  r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
         9:  r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
         12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
         15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
         18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
         21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
         24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
         27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
         30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic kff_type gain_kff(input logic [2:0] mode, input int axis);
      kff_type r;
      unique case (mode)
         MODE_VELOCITY, MODE_PASS: r = KFF_PLUS;
         MODE_MIX_UP:   r = (axis == 2) ? KFF_PLUS : KFF_ZERO;
         MODE_MIX_DOWN: r = (axis == 2) ? KFF_MINUS : KFF_ZERO;
         default:       r = KFF_ZERO;
      endcase
      return r;
   endfunction

   function automatic kp_type gain_kp(input logic [2:0] mode, input int axis);
      kp_type r;
      unique case (mode)
         MODE_POSITION:              r = KP_ONE;
         MODE_MIX_UP, MODE_MIX_DOWN: r = (axis == 2) ? KP_ZERO : KP_FIFTH;
         default:                    r = KP_ZERO;
      endcase
      return r;
   endfunction

   function automatic logic gain_kyaw(input logic [2:0] mode);
      logic r;
      unique case (mode)
         MODE_POSITION, MODE_VELOCITY, MODE_MIX_UP, MODE_MIX_DOWN: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/bfvc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// bfvc_vec_cell
// one vectoring step of the yaw atan2 chain, registered
// ----------------------------------------------------------------------------
module bfvc_vec_cell import bfvc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  vec_state_type vec_in,
   output vec_state_type vec_out
);

   vec_state_type state_ff;
   vec_state_type state_in;

   always_comb begin
      if (!vec_in.y[39]) begin
         state_in.x   = vec_in.x + (vec_in.y >>> STEP);
         state_in.y   = vec_in.y - (vec_in.x >>> STEP);
         state_in.acc = vec_in.acc + atan_turn(STEP);
      end else begin
         state_in.x   = vec_in.x - (vec_in.y >>> STEP);
         state_in.y   = vec_in.y + (vec_in.x >>> STEP);
         state_in.acc = vec_in.acc - atan_turn(STEP);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign vec_out = state_ff;

endmodule

// ===== hdl/bfvc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// bfvc_rot_cell
// one rotation step of the cos/sin chain, registered
// ----------------------------------------------------------------------------
module bfvc_rot_cell import bfvc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  rot_state_type rot_in,
   output rot_state_type rot_out
);

   rot_state_type state_ff;
   rot_state_type state_in;

   always_comb begin
      if (!rot_in.a[31]) begin
         state_in.x = rot_in.x - (rot_in.y >>> STEP);
         state_in.y = rot_in.y + (rot_in.x >>> STEP);
         state_in.a = rot_in.a - atan_turn(STEP);
      end else begin
         state_in.x = rot_in.x + (rot_in.y >>> STEP);
         state_in.y = rot_in.y - (rot_in.x >>> STEP);
         state_in.a = rot_in.a + atan_turn(STEP);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign rot_out = state_ff;

endmodule

// ===== hdl/bfvc_div_cell.sv =====
// ----------------------------------------------------------------------------
// bfvc_div_cell
// one chunk of a long division by five, most significant chunk first
// ----------------------------------------------------------------------------
module bfvc_div_cell import bfvc_pkg::*; #(
   parameter int CHUNK = 0
) (
   input  logic          clock,
   input  div_state_type div_in,
   output div_state_type div_out
);

   div_state_type      state_ff;
   div_state_type      state_in;
   logic [16:0]        num;
   logic [33:0]        scaled;
   logic [15:0]        quot;
   logic [16:0]        back;

   always_comb begin
      num      = {div_in.rem, div_in.u[CHUNK*DIV_CHUNK +: DIV_CHUNK]};
      scaled   = 34'(num) * 34'(RECIP_FIVE);
      quot     = scaled[33:18];
      back     = num - ((17'(quot) << 2) + 17'(quot));
      state_in = div_in;
      state_in.u[CHUNK*DIV_CHUNK +: DIV_CHUNK] = quot[DIV_CHUNK-1:0];
      state_in.rem = back[2:0];
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign div_out = state_ff;

endmodule

// ===== hdl/body_frame_velocity_command_core.sv =====
// ----------------------------------------------------------------------------
// body_frame_velocity_command_core
// body-frame velocity and heading-rate command from position and attitude
// ----------------------------------------------------------------------------
// A fully pipelined datapath: a transaction is taken in every cycle that start
// is high (busy is always low). Its result sits on the rsp_ ports with
// rsp_valid for one cycle. The latency is set by the two 31-cell cordic
// chains (yaw atan2, then cos/sin), plus input, multiply, sum, scale, three
// divide-by-five cells and output registers. The receiver cannot stall, so
// results must be taken as they come.
module body_frame_velocity_command_core import bfvc_pkg::*; #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [62:0]        req_des_pos_packed,
   input  logic [62:0]        req_odom_pos_packed,
   input  logic signed [31:0] req_des_vel_x,
   input  logic signed [31:0] req_des_vel_y,
   input  logic signed [31:0] req_des_vel_z,
   input  logic signed [15:0] req_des_heading,
   input  logic signed [31:0] req_des_heading_rate,
   input  logic [63:0]        req_odom_quat_packed,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_cmd_vel_x,
   output logic signed [31:0] rsp_cmd_vel_y,
   output logic signed [31:0] rsp_cmd_vel_z,
   output logic signed [31:0] rsp_cmd_heading_rate
);

   localparam int QSHIFT    = 32 - ANGLE_WIDTH;
   localparam logic [31:0] ANGLE_HALF = 32'd1 << (31 - ANGLE_WIDTH);
   localparam int HP_WIDTH  = ANGLE_WIDTH + 32;
   localparam logic signed [HP_WIDTH-1:0] RATE_HALF = HP_WIDTH'(1) << (ANGLE_WIDTH + 11);
   localparam int ST_VEC    = ITERS;
   localparam int ST_ROT0   = ITERS + 1;
   localparam int ST_MUL    = 2 * ITERS + 1;
   localparam int ST_SUM    = ST_MUL + 1;
   localparam int ST_BIAS   = ST_SUM + 1;
   localparam int ST_LAST   = ST_BIAS + DIV_CELLS;
   localparam int LATENCY   = ST_LAST + 2;
   localparam logic signed [69:0] Z_HALF = 70'sd2684354560;
   localparam logic [DIV_WIDTH-1:0] U_BIAS = DIV_WIDTH'(5) << 37;

   logic                    accept;
   logic [ST_LAST:0]        valid_ff;
   logic [ST_LAST:0]        valid_in;
   payload_type             head_in;
   payload_type             pipe_ff [0:ST_LAST];
   payload_type             pipe_in [0:ST_LAST];

   logic signed [15:0]      qw, qx, qy, qz;
   logic signed [31:0]      pww_ff, pxx_ff, pyy_ff, pzz_ff, pxy_ff, pwz_ff;

   vec_state_type           vec_link [0:ITERS];
   rot_state_type           rot_link [0:ITERS];
   logic signed [39:0]      vx0, vy0;
   logic [31:0]             yaw_acc, yaw_sum, rot_a0, rot_chk;
   logic [ANGLE_WIDTH-1:0]  yaw_q;

   logic signed [65:0]      cvx_ff, svy_ff, svx_ff, cvy_ff;
   logic signed [55:0]      cex_ff, sey_ff, sex_ff, cey_ff;
   logic signed [HP_WIDTH-1:0] hprod_ff;
   logic [31:0]             hsum;
   logic [ANGLE_WIDTH-1:0]  hdg_q, yaw_m, err_q;

   logic signed [66:0]      bv_ff [0:2];
   logic signed [66:0]      bv_in [0:2];
   logic signed [62:0]      be_ff [0:2];
   logic signed [62:0]      be_in [0:2];
   logic signed [HP_WIDTH-1:0] rate_full;

   div_state_type           div_link [0:2][0:DIV_CELLS];
   logic [DIV_WIDTH-1:0]    div_u_in [0:2];
   logic [DIV_WIDTH-1:0]    div_u_ff [0:2];
   logic signed [69:0]      bv_sel [0:2];
   logic signed [69:0]      be_sel [0:2];
   logic signed [69:0]      zval [0:2];

   logic signed [DIV_WIDTH:0] quot_s [0:2];
   logic signed [31:0]      sat_v [0:2];
   logic signed [31:0]      rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_r_ff;
   logic signed [31:0]      rsp_x_in, rsp_y_in, rsp_z_in, rsp_r_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // input capture
   always_comb begin
      qw = req_odom_quat_packed[15:0];
      qx = req_odom_quat_packed[31:16];
      qy = req_odom_quat_packed[47:32];
      qz = req_odom_quat_packed[63:48];
      head_in.mode      = req_mode;
      head_in.vel_x     = req_des_vel_x;
      head_in.vel_y     = req_des_vel_y;
      head_in.vel_z     = req_des_vel_z;
      head_in.hdg_rate  = req_des_heading_rate;
      head_in.err_x     = 22'($signed(req_des_pos_packed[20:0]))
                        - 22'($signed(req_odom_pos_packed[20:0]));
      head_in.err_y     = 22'($signed(req_des_pos_packed[41:21]))
                        - 22'($signed(req_odom_pos_packed[41:21]));
      head_in.err_z     = 22'($signed(req_des_pos_packed[62:42]))
                        - 22'($signed(req_odom_pos_packed[62:42]));
      head_in.heading   = req_des_heading;
      head_in.zero_quat = 1'b0;
      head_in.yaw_turn  = 32'd0;
      head_in.cmd_rate  = 32'd0;
   end

   always_ff @(posedge clock) begin
      pww_ff <= qw * qw;
      pxx_ff <= qx * qx;
      pyy_ff <= qy * qy;
      pzz_ff <= qz * qz;
      pxy_ff <= qx * qy;
      pwz_ff <= qw * qz;
   end

   // atan2 chain
   always_comb begin
      vx0 = 40'(pww_ff) + 40'(pxx_ff) - 40'(pyy_ff) - 40'(pzz_ff);
      vy0 = (40'(pxy_ff) + 40'(pwz_ff)) <<< 1;
      if (vx0[39]) begin
         vec_link[0].x   = -vx0;
         vec_link[0].y   = -vy0;
         vec_link[0].acc = 32'h8000_0000;
      end else begin
         vec_link[0].x   = vx0;
         vec_link[0].y   = vy0;
         vec_link[0].acc = 32'd0;
      end
   end

   for (genvar k = 0; k < ITERS; k++) begin : g_vec
      bfvc_vec_cell #(.STEP(k)) u_vec (
         .clock  (clock),
         .vec_in (vec_link[k]),
         .vec_out(vec_link[k+1])
      );
   end

   // yaw quantization and cos/sin chain
   always_comb begin
      yaw_acc = pipe_ff[ST_VEC].zero_quat ? 32'd0 : vec_link[ITERS].acc;
      yaw_sum = yaw_acc + ANGLE_HALF;
      yaw_q   = yaw_sum[31 -: ANGLE_WIDTH];
      rot_a0  = {yaw_q, {QSHIFT{1'b0}}};
      rot_chk = rot_a0 + 32'h4000_0000;
      rot_link[0].y = 34'sd0;
      if (rot_chk[31]) begin
         rot_link[0].x = -COS_GAIN_Q30;
         rot_link[0].a = rot_a0 + 32'h8000_0000;
      end else begin
         rot_link[0].x = COS_GAIN_Q30;
         rot_link[0].a = rot_a0;
      end
   end

   for (genvar k = 0; k < ITERS; k++) begin : g_rot
      bfvc_rot_cell #(.STEP(k)) u_rot (
         .clock  (clock),
         .rot_in (rot_link[k]),
         .rot_out(rot_link[k+1])
      );
   end

   // rotation products and heading error
   always_comb begin
      hsum  = {pipe_ff[ST_MUL-1].heading, 16'd0} + ANGLE_HALF;
      hdg_q = hsum[31 -: ANGLE_WIDTH];
      yaw_m = pipe_ff[ST_MUL-1].yaw_turn[31 -: ANGLE_WIDTH];
      err_q = hdg_q - yaw_m;
   end

   always_ff @(posedge clock) begin
      cvx_ff   <= 66'(rot_link[ITERS].x) * 66'(pipe_ff[ST_MUL-1].vel_x);
      svy_ff   <= 66'(rot_link[ITERS].y) * 66'(pipe_ff[ST_MUL-1].vel_y);
      svx_ff   <= 66'(rot_link[ITERS].y) * 66'(pipe_ff[ST_MUL-1].vel_x);
      cvy_ff   <= 66'(rot_link[ITERS].x) * 66'(pipe_ff[ST_MUL-1].vel_y);
      cex_ff   <= 56'(rot_link[ITERS].x) * 56'(pipe_ff[ST_MUL-1].err_x);
      sey_ff   <= 56'(rot_link[ITERS].y) * 56'(pipe_ff[ST_MUL-1].err_y);
      sex_ff   <= 56'(rot_link[ITERS].y) * 56'(pipe_ff[ST_MUL-1].err_x);
      cey_ff   <= 56'(rot_link[ITERS].x) * 56'(pipe_ff[ST_MUL-1].err_y);
      hprod_ff <= HP_WIDTH'($signed(err_q)) * HP_WIDTH'(PI_Q29);
   end

   // body-frame sums
   always_comb begin
      bv_in[0]  = 67'(cvx_ff) + 67'(svy_ff);
      bv_in[1]  = 67'(cvy_ff) - 67'(svx_ff);
      bv_in[2]  = 67'(pipe_ff[ST_SUM-1].vel_z) <<< 30;
      be_in[0]  = (63'(cex_ff) + 63'(sey_ff)) <<< 6;
      be_in[1]  = (63'(cey_ff) - 63'(sex_ff)) <<< 6;
      be_in[2]  = 63'(pipe_ff[ST_SUM-1].err_z) <<< 36;
      rate_full = (hprod_ff + RATE_HALF) >>> (ANGLE_WIDTH + 12);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         bv_ff[i] <= bv_in[i];
         be_ff[i] <= be_in[i];
      end
   end

   // gain scaling, rounding offset and bias ahead of the divide by five
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unique case (gain_kff(pipe_ff[ST_SUM].mode, i))
            KFF_PLUS:  bv_sel[i] = 70'(bv_ff[i]);
            KFF_MINUS: bv_sel[i] = -70'(bv_ff[i]);
            default:   bv_sel[i] = 70'sd0;
         endcase
         unique case (gain_kp(pipe_ff[ST_SUM].mode, i))
            KP_ONE:   be_sel[i] = (70'(be_ff[i]) <<< 2) + 70'(be_ff[i]);
            KP_FIFTH: be_sel[i] = 70'(be_ff[i]);
            default:  be_sel[i] = 70'sd0;
         endcase
         zval[i] = (bv_sel[i] <<< 2) + bv_sel[i] + be_sel[i] + Z_HALF;
         div_u_in[i] = DIV_WIDTH'($signed(zval[i][69:30])) + U_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         div_u_ff[i] <= div_u_in[i];
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign div_link[a][0].u   = div_u_ff[a];
      assign div_link[a][0].rem = 3'd0;
      for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
         bfvc_div_cell #(.CHUNK(DIV_CELLS - 1 - j)) u_div (
            .clock  (clock),
            .div_in (div_link[a][j]),
            .div_out(div_link[a][j+1])
         );
      end
   end

   // payload line
   always_comb begin
      pipe_in[0]  = head_in;
      valid_in[0] = accept;
      for (int i = 1; i <= ST_LAST; i++) begin
         pipe_in[i]  = pipe_ff[i-1];
         valid_in[i] = valid_ff[i-1];
      end
      pipe_in[1].zero_quat = (vx0 == 40'sd0) && (vy0 == 40'sd0);
      pipe_in[ST_ROT0].yaw_turn = rot_a0;
      pipe_in[ST_SUM].cmd_rate = gain_kyaw(pipe_ff[ST_SUM-1].mode)
                                 ? rate_full[31:0] : 32'd0;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= ST_LAST; i++) begin
         pipe_ff[i] <= pipe_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // saturation, passthrough and result register
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quot_s[i] = $signed({1'b0, div_link[i][DIV_CELLS].u})
                     - $signed((DIV_WIDTH+1)'(1) << 37);
         if (quot_s[i] > (DIV_WIDTH+1)'(32'sh7FFF_FFFF)) begin
            sat_v[i] = 32'sh7FFF_FFFF;
         end else if (quot_s[i] < -((DIV_WIDTH+1)'(1) << 31)) begin
            sat_v[i] = 32'sh8000_0000;
         end else begin
            sat_v[i] = quot_s[i][31:0];
         end
      end
      if (pipe_ff[ST_LAST].mode == MODE_PASS) begin
         rsp_x_in = pipe_ff[ST_LAST].vel_x;
         rsp_y_in = pipe_ff[ST_LAST].vel_y;
         rsp_z_in = pipe_ff[ST_LAST].vel_z;
         rsp_r_in = pipe_ff[ST_LAST].hdg_rate;
      end else begin
         rsp_x_in = sat_v[0];
         rsp_y_in = sat_v[1];
         rsp_z_in = sat_v[2];
         rsp_r_in = pipe_ff[ST_LAST].cmd_rate;
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      rsp_r_ff <= rsp_r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[ST_LAST];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cmd_vel_x        = rsp_x_ff;
   assign rsp_cmd_vel_y        = rsp_y_ff;
   assign rsp_cmd_vel_z        = rsp_z_ff;
   assign rsp_cmd_heading_rate = rsp_r_ff;

`ifndef SYNTHESIS
   a_result_has_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a transaction");

   a_passthrough_copies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_mode, LATENCY) == MODE_PASS) |->
      (rsp_cmd_vel_x == $past(req_des_vel_x, LATENCY)) &&
      (rsp_cmd_heading_rate == $past(req_des_heading_rate, LATENCY)))
      else $error("passthrough result differs from request");

   a_zero_modes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (($past(req_mode, LATENCY) == MODE_ZERO_LO) ||
      ($past(req_mode, LATENCY) == MODE_HOLD) ||
      ($past(req_mode, LATENCY) == MODE_ZERO_HI)) |->
      (rsp_cmd_vel_x == 32'sd0) && (rsp_cmd_vel_y == 32'sd0) &&
      (rsp_cmd_vel_z == 32'sd0) && (rsp_cmd_heading_rate == 32'sd0))
      else $error("zero mode gave a nonzero command");
`endif

endmodule
